>>> sv/tcce_pkg.sv
// tcce_pkg: shared constants and codes for the text console cell engine
`timescale 1ns / 1ps

package tcce_pkg;

  // default geometry
  localparam int unsigned DefNumScreens = 4;
  localparam int unsigned DefColumns    = 80;
  localparam int unsigned DefRows       = 25;

  // fixed field widths
  localparam int unsigned CharW    = 8;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned SelW     = 4;
  localparam int unsigned AddrInW  = 11;
  localparam int unsigned CurOutW  = 11;
  localparam int unsigned ScrOutW  = 2;
  localparam int unsigned TabW     = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // command codes
  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE  = 3'd0,
    FUNC_CLEAR  = 3'd1,
    FUNC_NEXT   = 3'd2,
    FUNC_PREV   = 3'd3,
    FUNC_SELECT = 3'd4,
    FUNC_READ   = 3'd5
  } func_e;

  // character codes
  localparam logic [CharW-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [CharW-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CharW-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CharW-1:0] CHAR_NEWLINE   = 8'h0A;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TAB_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PROMPT    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ATTRIBUTE = 2'd2;

  // register reset values
  localparam logic [TabW-1:0]  TabWidthRst  = 5'd4;
  localparam logic [CharW-1:0] PromptRst    = 8'd219;
  localparam logic [CharW-1:0] AttributeRst = 8'd2;

endpackage

>>> sv/tcce_cell_ram.sv
// tcce_cell_ram: single write port, single read port cell memory with registered read
`timescale 1ns / 1ps

module tcce_cell_ram #(
  parameter int unsigned DEPTH  = 8000,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [tcce_pkg::CharW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [tcce_pkg::CharW-1:0] rdata_o
);

  logic [tcce_pkg::CharW-1:0] mem_q [DEPTH];
  logic [tcce_pkg::CharW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/text_console_cell_engine.sv
// text_console_cell_engine: multi-screen text console, cell memory and cursor control
// Usage: one request on the input channel (func, char_code, screen_select, cell_address)
// gives exactly one result on the output channel (status, cursor, active screen, empty
// flag, scrolled flag, cell_char). Both channels use valid/ready. Configuration
// registers (tab width, prompt block char, attribute) are written through cfg_we_i,
// cfg_index_i and cfg_wdata_i while no request is in flight.
// Timing: a request writes or copies its cells one per cycle through the single write
// port of the cell memory. A new request is taken only once the previous result has
// moved into the output register.
// Reset: all cursors go to zero, all screens are marked empty and screen 0 is active;
// then a clearing pass writes a space into every cell, one per cycle, NUM_SCREENS *
// COLUMNS * ROWS cells (8000 by default), with in_ready_o low throughout.
// Stall: the result is held in an output register; while it waits and a further
// result is due, in_ready_o stays low.
`timescale 1ns / 1ps

module text_console_cell_engine #(
  parameter int unsigned NUM_SCREENS = tcce_pkg::DefNumScreens,
  parameter int unsigned COLUMNS     = tcce_pkg::DefColumns,
  parameter int unsigned ROWS        = tcce_pkg::DefRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tcce_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tcce_pkg::CfgDataW-1:0] cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcce_pkg::FuncW-1:0]    func_i,
  input  logic [tcce_pkg::CharW-1:0]    char_code_i,
  input  logic [tcce_pkg::SelW-1:0]     screen_select_i,
  input  logic [tcce_pkg::AddrInW-1:0]  cell_address_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [tcce_pkg::CurOutW-1:0]  cursor_position_o,
  output logic [tcce_pkg::ScrOutW-1:0]  active_screen_o,
  output logic                          screen_is_empty_o,
  output logic                          scrolled_o,
  output logic [tcce_pkg::CharW-1:0]    cell_char_o
);

  localparam int unsigned ScreenCells = COLUMNS * ROWS;
  localparam int unsigned MoveCells   = COLUMNS * (ROWS - 1);
  localparam int unsigned Depth       = NUM_SCREENS * ScreenCells;
  localparam int unsigned AW          = $clog2(Depth);
  localparam int unsigned CW          = $clog2(ScreenCells);
  localparam int unsigned ColW        = $clog2(COLUMNS);
  localparam int unsigned SW          = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;
  localparam int unsigned RemW        = $clog2(COLUMNS + 1);

  localparam logic [CW-1:0]   LastCell  = CW'(ScreenCells - 1);
  localparam logic [CW-1:0]   MoveCur   = CW'(MoveCells);
  localparam logic [ColW-1:0] LastCol   = ColW'(COLUMNS - 1);
  localparam logic [SW-1:0]   LastScr   = SW'(NUM_SCREENS - 1);
  localparam logic [AW-1:0]   LastAddr  = AW'(Depth - 1);
  localparam logic [AW-1:0]   RowStep   = AW'(COLUMNS);
  localparam logic [AW-1:0]   ScrSpan   = AW'(ScreenCells - 1);
  localparam logic [AW-1:0]   MoveSpan  = AW'(MoveCells);
  localparam logic [RemW-1:0] RowLen    = RemW'(COLUMNS);
  localparam logic [tcce_pkg::SelW:0] NumScrL = (tcce_pkg::SelW + 1)'(NUM_SCREENS);

  // sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_BSCMP = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_POST  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [AW-1:0]   walk_q, walk_d;
  logic [AW-1:0]   walk_last_q, walk_last_d;
  logic [AW-1:0]   copy_lim_q, copy_lim_d;
  logic [RemW-1:0] rem_q, rem_d;

  // captured request
  logic [tcce_pkg::FuncW-1:0]   func_q;
  logic [tcce_pkg::CharW-1:0]   ch_q;
  logic [tcce_pkg::SelW-1:0]    sel_q;
  logic [tcce_pkg::AddrInW-1:0] addr_q;

  // screen state
  logic [SW-1:0]   scr_q, scr_d;
  logic [AW-1:0]   base_q, base_d;
  logic [CW-1:0]   cur_q [NUM_SCREENS];
  logic [CW-1:0]   cur_d [NUM_SCREENS];
  logic [ColW-1:0] col_q [NUM_SCREENS];
  logic [ColW-1:0] col_d [NUM_SCREENS];
  logic            empty_q [NUM_SCREENS];
  logic            empty_d [NUM_SCREENS];
  logic [CW-1:0]   cur_rd;
  logic [ColW-1:0] col_rd;
  logic [ColW-1:0] col_inc;
  logic [ColW-1:0] col_dec;

  // configuration, the attribute byte is stored here but drives no output
  logic [tcce_pkg::TabW-1:0]  tab_w_q;
  logic [tcce_pkg::CharW-1:0] prompt_q;
  logic [tcce_pkg::CharW-1:0] attr_q;

  // pending result
  logic pend_q, pend_d;
  logic status_q, status_d;
  logic scrolled_q, scrolled_d;
  logic rdsel_q, rdsel_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic                         out_free;
  logic                         flush;
  logic                         accept;
  logic                         o_status_q;
  logic [tcce_pkg::CurOutW-1:0] o_cursor_q;
  logic [tcce_pkg::ScrOutW-1:0] o_screen_q;
  logic                         o_empty_q;
  logic                         o_scrolled_q;
  logic [tcce_pkg::CharW-1:0]   o_char_q;

  // memory write stage and read request
  logic                       wr_valid_q, wr_valid_d;
  logic [AW-1:0]              wr_addr_q, wr_addr_d;
  logic                       wr_copy_q, wr_copy_d;
  logic [tcce_pkg::CharW-1:0] wr_data_q, wr_data_d;
  logic [tcce_pkg::CharW-1:0] ram_wdata;
  logic [tcce_pkg::CharW-1:0] rd_data;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;

  tcce_cell_ram #(
    .DEPTH  (Depth),
    .ADDR_W (AW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (wr_valid_q),
    .waddr_i (wr_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // copies during a scroll take the data read in the previous cycle
  assign ram_wdata = wr_copy_q ? rd_data : wr_data_q;

  // cursor of the active screen
  assign cur_rd  = cur_q[scr_q];
  assign col_rd  = col_q[scr_q];
  assign col_inc = (col_rd == LastCol) ? '0 : col_rd + 1'b1;
  assign col_dec = (col_rd == '0) ? LastCol : col_rd - 1'b1;

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign flush      = pend_q && out_free;
  assign in_ready_o = (state_q == S_IDLE) && (!pend_q || out_free);
  assign accept     = in_valid_i && in_ready_o;

  // sequencer
  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    walk_last_d = walk_last_q;
    copy_lim_d  = copy_lim_q;
    rem_d       = rem_q;
    scr_d       = scr_q;
    cur_d       = cur_q;
    col_d       = col_q;
    empty_d     = empty_q;
    pend_d      = pend_q;
    status_d    = status_q;
    scrolled_d  = scrolled_q;
    rdsel_d     = rdsel_q;
    wr_valid_d  = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_copy_d   = 1'b0;
    wr_data_d   = wr_data_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (flush) begin
      pend_d = 1'b0;
    end

    case (state_q)
      // clear every cell after reset
      S_INIT: begin
        wr_valid_d = 1'b1;
        wr_addr_d  = walk_q;
        wr_data_d  = tcce_pkg::CHAR_SPACE;
        if (walk_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      // first cycle of a request
      S_EXEC: begin
        status_d   = 1'b0;
        scrolled_d = 1'b0;
        rdsel_d    = 1'b0;
        state_d    = S_IDLE;
        pend_d     = 1'b1;
        case (func_q)
          tcce_pkg::FUNC_WRITE: begin
            empty_d[scr_q] = 1'b0;
            case (ch_q)
              tcce_pkg::CHAR_NEWLINE: begin
                pend_d = 1'b0;
                if (cur_rd >= MoveCur) begin
                  walk_d      = base_q;
                  walk_last_d = base_q + ScrSpan;
                  copy_lim_d  = base_q + MoveSpan;
                  state_d     = S_WALK;
                end else begin
                  rem_d   = RowLen - RemW'(col_rd);
                  state_d = S_FILL;
                end
              end
              tcce_pkg::CHAR_TAB: begin
                if (tab_w_q != '0) begin
                  pend_d  = 1'b0;
                  rem_d   = RemW'(tab_w_q);
                  state_d = S_FILL;
                end
              end
              tcce_pkg::CHAR_BACKSPACE: begin
                if (cur_rd != '0) begin
                  pend_d    = 1'b0;
                  ram_re    = 1'b1;
                  ram_raddr = base_q + AW'(cur_rd) - 1'b1;
                  state_d   = S_BSCMP;
                end
              end
              default: begin
                if (cur_rd == LastCell) begin
                  pend_d      = 1'b0;
                  walk_d      = base_q;
                  walk_last_d = base_q + ScrSpan;
                  copy_lim_d  = base_q + MoveSpan;
                  state_d     = S_WALK;
                end else begin
                  wr_valid_d    = 1'b1;
                  wr_addr_d     = base_q + AW'(cur_rd);
                  wr_data_d     = ch_q;
                  cur_d[scr_q]  = cur_rd + 1'b1;
                  col_d[scr_q]  = col_inc;
                end
              end
            endcase
          end
          tcce_pkg::FUNC_CLEAR: begin
            pend_d         = 1'b0;
            cur_d[scr_q]   = '0;
            col_d[scr_q]   = '0;
            empty_d[scr_q] = 1'b1;
            walk_d         = base_q;
            walk_last_d    = base_q + ScrSpan;
            copy_lim_d     = base_q;
            state_d        = S_WALK;
          end
          tcce_pkg::FUNC_NEXT: begin
            scr_d = (scr_q == LastScr) ? '0 : scr_q + 1'b1;
          end
          tcce_pkg::FUNC_PREV: begin
            scr_d = (scr_q == '0) ? LastScr : scr_q - 1'b1;
          end
          tcce_pkg::FUNC_SELECT: begin
            if ({1'b0, sel_q} >= NumScrL) begin
              status_d = 1'b1;
            end else begin
              scr_d = SW'(sel_q);
            end
          end
          tcce_pkg::FUNC_READ: begin
            if (32'(addr_q) < 32'(ScreenCells)) begin
              ram_re    = 1'b1;
              ram_raddr = base_q + AW'(addr_q);
              rdsel_d   = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // backspace: erase unless the previous cell holds the prompt block
      S_BSCMP: begin
        if (rd_data != prompt_q) begin
          wr_valid_d   = 1'b1;
          wr_addr_d    = base_q + AW'(cur_rd) - 1'b1;
          wr_data_d    = tcce_pkg::CHAR_SPACE;
          cur_d[scr_q] = cur_rd - 1'b1;
          col_d[scr_q] = col_dec;
        end
        state_d = S_IDLE;
        pend_d  = 1'b1;
      end

      // spaces for tab and newline padding, stopping at the last cell
      S_FILL: begin
        wr_valid_d = 1'b1;
        wr_addr_d  = base_q + AW'(cur_rd);
        wr_data_d  = tcce_pkg::CHAR_SPACE;
        rem_d      = rem_q - 1'b1;
        if (cur_rd == LastCell) begin
          state_d = S_IDLE;
          pend_d  = 1'b1;
        end else begin
          cur_d[scr_q] = cur_rd + 1'b1;
          col_d[scr_q] = col_inc;
          if (rem_q == RemW'(1)) begin
            state_d = S_IDLE;
            pend_d  = 1'b1;
          end
        end
      end

      // screen walk: for a scroll copy one row up, then blank the tail; for a clear blank every cell
      S_WALK: begin
        wr_valid_d = 1'b1;
        wr_addr_d  = walk_q;
        if (walk_q < copy_lim_q) begin
          ram_re    = 1'b1;
          ram_raddr = walk_q + RowStep;
          wr_copy_d = 1'b1;
        end else begin
          wr_data_d = tcce_pkg::CHAR_SPACE;
        end
        if (walk_q == walk_last_q) begin
          if (func_q == tcce_pkg::FUNC_CLEAR) begin
            state_d = S_IDLE;
            pend_d  = 1'b1;
          end else begin
            state_d = S_POST;
          end
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end

      // after a scroll: cursor to the last row; a plain character is written at its start
      S_POST: begin
        scrolled_d = 1'b1;
        if (ch_q == tcce_pkg::CHAR_NEWLINE) begin
          cur_d[scr_q] = MoveCur;
          col_d[scr_q] = '0;
        end else begin
          wr_valid_d   = 1'b1;
          wr_addr_d    = base_q + MoveSpan;
          wr_data_d    = ch_q;
          cur_d[scr_q] = MoveCur + 1'b1;
          col_d[scr_q] = ColW'(1);
        end
        state_d = S_IDLE;
        pend_d  = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // base address of the active screen
    base_d = AW'(scr_d * ScreenCells);
  end

  // output valid
  always_comb begin
    if (flush) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      walk_q      <= '0;
      walk_last_q <= '0;
      copy_lim_q  <= '0;
      rem_q       <= '0;
      scr_q       <= '0;
      base_q      <= '0;
      for (int i = 0; i < NUM_SCREENS; i++) begin
        cur_q[i]   <= '0;
        col_q[i]   <= '0;
        empty_q[i] <= 1'b1;
      end
      pend_q      <= 1'b0;
      status_q    <= 1'b0;
      scrolled_q  <= 1'b0;
      rdsel_q     <= 1'b0;
      out_valid_q <= 1'b0;
      wr_valid_q  <= 1'b0;
      wr_copy_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      walk_last_q <= walk_last_d;
      copy_lim_q  <= copy_lim_d;
      rem_q       <= rem_d;
      scr_q       <= scr_d;
      base_q      <= base_d;
      cur_q       <= cur_d;
      col_q       <= col_d;
      empty_q     <= empty_d;
      pend_q      <= pend_d;
      status_q    <= status_d;
      scrolled_q  <= scrolled_d;
      rdsel_q     <= rdsel_d;
      out_valid_q <= out_valid_d;
      wr_valid_q  <= wr_valid_d;
      wr_copy_q   <= wr_copy_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_w_q  <= tcce_pkg::TabWidthRst;
      prompt_q <= tcce_pkg::PromptRst;
      attr_q   <= tcce_pkg::AttributeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcce_pkg::CFG_TAB_WIDTH: tab_w_q  <= cfg_wdata_i[tcce_pkg::TabW-1:0];
        tcce_pkg::CFG_PROMPT:    prompt_q <= cfg_wdata_i;
        tcce_pkg::CFG_ATTRIBUTE: attr_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      ch_q   <= char_code_i;
      sel_q  <= screen_select_i;
      addr_q <= cell_address_i;
    end
  end

  // write stage payload
  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    wr_data_q <= wr_data_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (flush) begin
      o_status_q   <= status_q;
      o_cursor_q   <= tcce_pkg::CurOutW'(cur_rd);
      o_screen_q   <= tcce_pkg::ScrOutW'(scr_q);
      o_empty_q    <= empty_q[scr_q];
      o_scrolled_q <= scrolled_q;
      o_char_q     <= rdsel_q ? rd_data : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = o_status_q;
  assign cursor_position_o = o_cursor_q;
  assign active_screen_o   = o_screen_q;
  assign screen_is_empty_o = o_empty_q;
  assign scrolled_o        = o_scrolled_q;
  assign cell_char_o       = o_char_q;

endmodule

>>> verif/text_console_cell_engine_tb.sv
// text_console_cell_engine_tb: random and directed self-checking testbench with a scoreboard
`timescale 1ns / 1ps

module text_console_cell_engine_tb;

  localparam int unsigned SCREENS          = tcce_pkg::DefNumScreens;
  localparam int unsigned COLS             = tcce_pkg::DefColumns;
  localparam int unsigned ROWS             = tcce_pkg::DefRows;
  localparam int unsigned SCREEN_CELLS     = COLS * ROWS;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned ITEMS_PER_PHASE  = 125;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES    = 64;
  localparam longint      TIMEOUT_NS       = 100_000_000;

  // spare command codes, the block treats them as no-ops
  localparam logic [tcce_pkg::FuncW-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [tcce_pkg::FuncW-1:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [tcce_pkg::FuncW-1:0]   func;
    logic [tcce_pkg::CharW-1:0]   char_code;
    logic [tcce_pkg::SelW-1:0]    sel;
    logic [tcce_pkg::AddrInW-1:0] addr;
  } console_cmd_t;

  typedef struct packed {
    logic                         status;
    logic [tcce_pkg::CurOutW-1:0] cursor;
    logic [tcce_pkg::ScrOutW-1:0] screen;
    logic                         blank;
    logic                         scrolled;
    logic [tcce_pkg::CharW-1:0]   cell_char;
  } screen_report_t;

  // scoreboard: own copy of the screens, predicts one report per request
  class console_scoreboard;
    bit [tcce_pkg::CharW-1:0] glyph_mem [SCREENS * SCREEN_CELLS];
    int unsigned              caret_pos [SCREENS];
    bit                       is_blank [SCREENS];
    int unsigned              shown_screen;
    bit [tcce_pkg::TabW-1:0]  tab_width;
    bit [tcce_pkg::CharW-1:0] prompt_char;
    bit [tcce_pkg::CharW-1:0] attribute;
    screen_report_t           reports_due [$];
    int unsigned              error_count;

    function new();
      foreach (glyph_mem[i]) glyph_mem[i] = tcce_pkg::CHAR_SPACE;
      foreach (caret_pos[i]) begin
        caret_pos[i] = 0;
        is_blank[i]  = 1'b1;
      end
      shown_screen = 0;
      tab_width    = tcce_pkg::TabWidthRst;
      prompt_char  = tcce_pkg::PromptRst;
      attribute    = tcce_pkg::AttributeRst;
      error_count  = 0;
    endfunction

    function void set_register(logic [tcce_pkg::CfgIdxW-1:0] idx,
                               logic [tcce_pkg::CfgDataW-1:0] val);
      case (idx)
        tcce_pkg::CFG_TAB_WIDTH: tab_width = val[tcce_pkg::TabW-1:0];
        tcce_pkg::CFG_PROMPT:    prompt_char = val;
        tcce_pkg::CFG_ATTRIBUTE: attribute = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction

    function int unsigned active_cursor();
      return caret_pos[shown_screen];
    endfunction

    // move every row up by one, blank the bottom row
    function void shift_rows_up();
      int unsigned base;
      base = shown_screen * SCREEN_CELLS;
      for (int unsigned i = 0; i < COLS * (ROWS - 1); i++)
        glyph_mem[base + i] = glyph_mem[base + i + COLS];
      for (int unsigned i = COLS * (ROWS - 1); i < SCREEN_CELLS; i++)
        glyph_mem[base + i] = tcce_pkg::CHAR_SPACE;
      caret_pos[shown_screen] = COLS * (ROWS - 1);
    endfunction

    // one character into the active screen, returns the scroll flag
    function bit put_glyph(bit [tcce_pkg::CharW-1:0] ch);
      int unsigned base;
      int unsigned cur;
      int unsigned row;
      bit          scr;
      base = shown_screen * SCREEN_CELLS;
      cur  = caret_pos[shown_screen];
      scr  = 1'b0;
      if (cur >= SCREEN_CELLS) cur = 0;
      is_blank[shown_screen] = 1'b0;
      if (ch == tcce_pkg::CHAR_NEWLINE) begin
        row = (cur / COLS) % ROWS;
        if (row == ROWS - 1) begin
          shift_rows_up();
          return 1'b1;
        end
        while (cur < COLS * (row + 1)) begin
          glyph_mem[base + cur] = tcce_pkg::CHAR_SPACE;
          cur++;
        end
      end else if (ch == tcce_pkg::CHAR_TAB) begin
        // spaces stop at the last cell
        for (int unsigned k = 0; k < 32'(tab_width); k++) begin
          glyph_mem[base + cur] = tcce_pkg::CHAR_SPACE;
          if (cur >= SCREEN_CELLS - 1) break;
          cur++;
        end
      end else if (ch == tcce_pkg::CHAR_BACKSPACE) begin
        if (cur > 0 && glyph_mem[base + cur - 1] != prompt_char) begin
          cur--;
          glyph_mem[base + cur] = tcce_pkg::CHAR_SPACE;
        end
      end else begin
        // plain character on the last cell scrolls first
        if (cur == SCREEN_CELLS - 1) begin
          shift_rows_up();
          cur = caret_pos[shown_screen];
          scr = 1'b1;
        end
        glyph_mem[base + cur] = ch;
        cur++;
      end
      caret_pos[shown_screen] = cur;
      return scr;
    endfunction

    function void predict_request(console_cmd_t c);
      screen_report_t r;
      int unsigned    base;
      r    = '0;
      base = shown_screen * SCREEN_CELLS;
      case (c.func)
        tcce_pkg::FUNC_WRITE: r.scrolled = put_glyph(c.char_code);
        tcce_pkg::FUNC_CLEAR: begin
          for (int unsigned i = 0; i < SCREEN_CELLS; i++)
            glyph_mem[base + i] = tcce_pkg::CHAR_SPACE;
          caret_pos[shown_screen] = 0;
          is_blank[shown_screen]  = 1'b1;
        end
        tcce_pkg::FUNC_NEXT:
          shown_screen = (shown_screen + 1 >= SCREENS) ? 0 : shown_screen + 1;
        tcce_pkg::FUNC_PREV:
          shown_screen = (shown_screen == 0) ? SCREENS - 1 : shown_screen - 1;
        tcce_pkg::FUNC_SELECT: begin
          if (32'(c.sel) >= SCREENS) r.status = 1'b1;
          else shown_screen = 32'(c.sel);
        end
        tcce_pkg::FUNC_READ: begin
          if (32'(c.addr) < SCREEN_CELLS) r.cell_char = glyph_mem[base + 32'(c.addr)];
        end
        default: ;
      endcase
      r.cursor = tcce_pkg::CurOutW'(caret_pos[shown_screen]);
      r.screen = tcce_pkg::ScrOutW'(shown_screen);
      r.blank  = is_blank[shown_screen];
      reports_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        error_count++;
        $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
      end
    endfunction

    function void check_result(screen_report_t got);
      screen_report_t want;
      if (reports_due.size() == 0) begin
        error_count++;
        $error("result with no request awaiting it");
        return;
      end
      want = reports_due.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("cursor_position", 16'(want.cursor), 16'(got.cursor));
      compare_field("active_screen", 16'(want.screen), 16'(got.screen));
      compare_field("screen_is_empty", 16'(want.blank), 16'(got.blank));
      compare_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
      compare_field("cell_char", 16'(want.cell_char), 16'(got.cell_char));
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tcce_pkg::CfgIdxW-1:0]  cfg_index;
  logic [tcce_pkg::CfgDataW-1:0] cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic [tcce_pkg::FuncW-1:0]    func;
  logic [tcce_pkg::CharW-1:0]    char_code;
  logic [tcce_pkg::SelW-1:0]     screen_select;
  logic [tcce_pkg::AddrInW-1:0]  cell_address;
  logic                          out_valid;
  logic                          out_ready;
  logic                          status;
  logic [tcce_pkg::CurOutW-1:0]  cursor_position;
  logic [tcce_pkg::ScrOutW-1:0]  active_screen;
  logic                          screen_is_empty;
  logic                          scrolled;
  logic [tcce_pkg::CharW-1:0]    cell_char;

  console_scoreboard sb;
  int unsigned       send_idle_pct = 6;
  int unsigned       recv_idle_pct = 88;
  int unsigned       requests_sent = 0;
  bit                long_hold_req = 1'b0;
  bit                long_hold_done = 1'b0;

  text_console_cell_engine u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .func_i            (func),
    .char_code_i       (char_code),
    .screen_select_i   (screen_select),
    .cell_address_i    (cell_address),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .cursor_position_o (cursor_position),
    .active_screen_o   (active_screen),
    .screen_is_empty_o (screen_is_empty),
    .scrolled_o        (scrolled),
    .cell_char_o       (cell_char)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random back-pressure, plus one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({status, cursor_position, active_screen, screen_is_empty, scrolled,
                       cell_char});
  end

  // present one request and hold it until taken; predict on acceptance
  task automatic send_cmd(input logic [tcce_pkg::FuncW-1:0] f,
                          input logic [tcce_pkg::CharW-1:0] ch,
                          input logic [tcce_pkg::SelW-1:0] sel,
                          input logic [tcce_pkg::AddrInW-1:0] addr);
    console_cmd_t cmd;
    cmd.func      = f;
    cmd.char_code = ch;
    cmd.sel       = sel;
    cmd.addr      = addr;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    char_code     <= ch;
    screen_select <= sel;
    cell_address  <= addr;
    do @(posedge clk); while (!in_ready);
    sb.predict_request(cmd);
    requests_sent++;
  endtask

  task automatic put_char(input logic [tcce_pkg::CharW-1:0] ch);
    send_cmd(tcce_pkg::FUNC_WRITE, ch, tcce_pkg::SelW'($urandom_range(15)),
             tcce_pkg::AddrInW'($urandom_range(2047)));
  endtask

  task automatic read_cell(input logic [tcce_pkg::AddrInW-1:0] addr);
    send_cmd(tcce_pkg::FUNC_READ, tcce_pkg::CharW'($urandom_range(255)),
             tcce_pkg::SelW'($urandom_range(15)), addr);
  endtask

  task automatic screen_cmd(input logic [tcce_pkg::FuncW-1:0] f,
                            input logic [tcce_pkg::SelW-1:0] sel);
    send_cmd(f, tcce_pkg::CharW'($urandom_range(255)), sel,
             tcce_pkg::AddrInW'($urandom_range(2047)));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcce_pkg::CfgIdxW-1:0] idx,
                           input logic [tcce_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, val);
  endtask

  task automatic apply_setting(input int unsigned phase);
    logic [tcce_pkg::CfgDataW-1:0] tab;
    logic [tcce_pkg::CfgDataW-1:0] prompt;
    logic [tcce_pkg::CfgDataW-1:0] attr;
    tab    = tcce_pkg::CfgDataW'($urandom_range(16, 1));
    prompt = tcce_pkg::CfgDataW'($urandom_range(255));
    attr   = tcce_pkg::CfgDataW'($urandom_range(255));
    case (phase)
      0: begin
        tab    = 8'd16;
        prompt = 8'd0;
        attr   = 8'd0;
      end
      1: begin
        tab    = 8'd1;
        prompt = 8'd255;
        attr   = 8'd255;
      end
      2: begin
        // no spaces for a tab, backspace blocked after any space
        tab    = 8'd0;
        prompt = tcce_pkg::CHAR_SPACE;
      end
      3: begin
        tab    = 8'd31;
        prompt = tcce_pkg::PromptRst;
        attr   = tcce_pkg::AttributeRst;
      end
      4: tab = 8'hE5; // upper bits ignored, five spaces
      default: ;
    endcase
    write_reg(tcce_pkg::CFG_TAB_WIDTH, tab);
    write_reg(tcce_pkg::CFG_PROMPT, prompt);
    write_reg(tcce_pkg::CFG_ATTRIBUTE, attr);
  endtask

  // text mix: mostly printable, some control codes and the prompt block
  function automatic logic [tcce_pkg::CharW-1:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return tcce_pkg::CHAR_TAB;
    else if (roll < 16) return tcce_pkg::CHAR_BACKSPACE;
    else if (roll < 21) return tcce_pkg::CHAR_NEWLINE;
    else if (roll < 25) return sb.prompt_char;
    else if (roll < 40) return tcce_pkg::CharW'($urandom_range(255));
    else return tcce_pkg::CharW'($urandom_range(126, 32));
  endfunction

  // walk down to the last row and fill it up to or near the edge, then one edge case
  task automatic run_to_screen_edge();
    int unsigned stop_at;
    while (((sb.active_cursor() / COLS) % ROWS) != ROWS - 1)
      put_char(tcce_pkg::CHAR_NEWLINE);
    stop_at = SCREEN_CELLS - 1 - $urandom_range(5);
    if ($urandom_range(2) == 0) stop_at = SCREEN_CELLS - 1;
    while (sb.active_cursor() < stop_at)
      put_char(tcce_pkg::CharW'($urandom_range(126, 32)));
    case ($urandom_range(4))
      0: put_char(tcce_pkg::CHAR_TAB);
      1: put_char(tcce_pkg::CHAR_NEWLINE);
      2: put_char(tcce_pkg::CHAR_BACKSPACE);
      default: put_char(tcce_pkg::CharW'($urandom_range(126, 32)));
    endcase
  endtask

  task automatic random_episode();
    int unsigned kind;
    int unsigned n;
    int unsigned roll;
    int unsigned near_end;
    kind = $urandom_range(99);
    if (kind < 40) begin
      n = $urandom_range(12, 1);
      repeat (n) put_char(pick_char());
    end else if (kind < 52) begin
      n = $urandom_range(6, 1);
      repeat (n) put_char(tcce_pkg::CHAR_NEWLINE);
    end else if (kind < 58) begin
      run_to_screen_edge();
    end else if (kind < 70) begin
      // reads mostly around the written text, some anywhere, some past the screen
      n = $urandom_range(3, 1);
      repeat (n) begin
        roll     = $urandom_range(99);
        near_end = sb.active_cursor() + 2;
        if (near_end > SCREEN_CELLS - 1) near_end = SCREEN_CELLS - 1;
        if (roll < 70) read_cell(tcce_pkg::AddrInW'($urandom_range(near_end)));
        else if (roll < 90) read_cell(tcce_pkg::AddrInW'($urandom_range(SCREEN_CELLS - 1)));
        else read_cell(tcce_pkg::AddrInW'($urandom_range(2047)));
      end
    end else if (kind < 84) begin
      case ($urandom_range(2))
        0: screen_cmd(tcce_pkg::FUNC_NEXT, tcce_pkg::SelW'($urandom_range(15)));
        1: screen_cmd(tcce_pkg::FUNC_PREV, tcce_pkg::SelW'($urandom_range(15)));
        default: screen_cmd(tcce_pkg::FUNC_SELECT, tcce_pkg::SelW'($urandom_range(15)));
      endcase
    end else if (kind < 86) begin
      screen_cmd(tcce_pkg::FUNC_CLEAR, tcce_pkg::SelW'($urandom_range(15)));
    end else begin
      send_cmd(tcce_pkg::FuncW'($urandom_range(7)), tcce_pkg::CharW'($urandom_range(255)),
               tcce_pkg::SelW'($urandom_range(15)), tcce_pkg::AddrInW'($urandom_range(2047)));
    end
  endtask

  // main sequence
  initial begin
    int unsigned phase_start;
    sb = new();
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    func          <= '0;
    char_code     <= '0;
    screen_select <= '0;
    cell_address  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every command, the special cases
    read_cell(11'd0);
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(tcce_pkg::CHAR_BACKSPACE);
    put_char(tcce_pkg::PromptRst);
    put_char(tcce_pkg::CHAR_BACKSPACE);
    put_char(tcce_pkg::CHAR_TAB);
    put_char(tcce_pkg::CHAR_NEWLINE);
    read_cell(11'd1);
    read_cell(tcce_pkg::AddrInW'(SCREEN_CELLS - 1));
    read_cell(11'h7FF);
    screen_cmd(tcce_pkg::FUNC_SELECT, 4'hF);
    screen_cmd(tcce_pkg::FUNC_SELECT, 4'd3);
    screen_cmd(tcce_pkg::FUNC_NEXT, 4'd0);
    screen_cmd(tcce_pkg::FUNC_PREV, 4'd0);
    screen_cmd(tcce_pkg::FUNC_PREV, 4'd0);
    put_char(tcce_pkg::CHAR_BACKSPACE);
    screen_cmd(FUNC_UNUSED_LO, 4'd0);
    screen_cmd(FUNC_UNUSED_HI, 4'hF);
    screen_cmd(tcce_pkg::FUNC_CLEAR, 4'd0);
    screen_cmd(tcce_pkg::FUNC_SELECT, 4'd0);
    read_cell(11'd0);

    // random phases, each with its own register setting; the idle pattern changes every two phases
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      apply_setting(phase);
      if (phase < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 88;
      end else if (phase < 4) begin
        send_idle_pct = 88;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 4) long_hold_req = 1'b1;
      phase_start = requests_sent;
      while (requests_sent - phase_start < ITEMS_PER_PHASE) random_episode();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
